// File: hw/rtl/byte_budget_fifo_cache_top_defines.svh
// Assertion macros for the byte budget FIFO cache.
// Used by the datapath; relies on signals clk and arst_n in the including module.
`ifndef BYTE_BUDGET_FIFO_CACHE_TOP_DEFINES_SVH
`define BYTE_BUDGET_FIFO_CACHE_TOP_DEFINES_SVH
// An invariant that holds at every clock edge outside reset.
`define BBFC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// A condition in one cycle implies another in the next cycle.
`define BBFC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`endif

// File: hw/rtl/bbfc_pkg.sv
// Package of the byte budget FIFO cache: sizes, payload types, states and
// the command and status groups between controller and datapath. No dependencies.
package bbfc_pkg;
	localparam int ENTRIES = 64;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam logic [31:0] BUDGET_RESET = 32'd1048576;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_COUNT = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [63:0] maker_number;
		logic [63:0] program_number;
		logic [63:0] release_number;
		logic [63:0] piece_number;
		logic [31:0] shard_bytes;
	} in_item_t;

	typedef struct packed {
		logic found;
		logic stored;
		logic too_large;
		logic [5:0] slot_index;
		logic [6:0] evicted_count;
		logic [6:0] group_count;
		logic [31:0] used_bytes;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} out_item_t;

	typedef struct packed {
		logic [63:0] maker;
		logic [63:0] software;
		logic [63:0] release_id;
		logic [63:0] piece;
	} key_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_CHECK,
		ST_EV_RD,
		ST_EVICT,
		ST_WRITE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic hit;
		logic miss;
		logic mark_large;
		logic evict_rd;
		logic evict;
		logic write;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic found;
		logic too_large;
		logic fits;
		logic empty;
		logic full;
		logic scan_done;
		logic out_free;
	} status_t;
endpackage

// File: hw/rtl/byte_budget_fifo_cache_top.sv
// Every transaction first scans all entries; a missed insert that fits the budget then
// evicts the oldest entries until the shard fits, or the single oldest entry of a full
// table, and writes the new entry (one table memory read port, shared by scan and eviction).
// The block takes one transaction at a time and stalls its input until the result is loaded.
// Reset clears pointers, counters and valid marks at once and loads the default budget.
// Top level of the byte budget FIFO cache; instantiates bbfc_ctrl and bbfc_datapath.
module byte_budget_fifo_cache_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bbfc_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output bbfc_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [31:0] cfg_wdata
);
	bbfc_pkg::cmd_t cmd;
	bbfc_pkg::status_t status;

	bbfc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status(status),
		.cmd(cmd)
	);

	bbfc_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.status(status),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);
endmodule

// File: hw/rtl/bbfc_ctrl.sv
// Controller state machine of the byte budget FIFO cache.
// Depends on bbfc_pkg for the state, command and status types.
module bbfc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input bbfc_pkg::status_t status,
	output bbfc_pkg::cmd_t cmd
);
	bbfc_pkg::state_t state_q, state_d;
	logic last_q, last_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bbfc_pkg::ST_IDLE;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			last_q <= last_d;
		end
	end

	always_comb begin
		state_d = state_q;
		last_d = last_q;
		cmd = '0;
		in_stall = (state_q != bbfc_pkg::ST_IDLE);
		case (state_q)
			bbfc_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					last_d = 1'b0;
					state_d = bbfc_pkg::ST_SCAN;
				end
			end
			bbfc_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) state_d = bbfc_pkg::ST_DECIDE;
			end
			bbfc_pkg::ST_DECIDE: begin
				state_d = bbfc_pkg::ST_DONE;
				if (status.op == bbfc_pkg::OP_INSERT) begin
					if (status.found) begin
						cmd.hit = 1'b1;
					end else begin
						cmd.miss = 1'b1;
						if (status.too_large) cmd.mark_large = 1'b1;
						else state_d = bbfc_pkg::ST_CHECK;
					end
				end
			end
			bbfc_pkg::ST_CHECK: begin
				if (status.fits || status.empty) begin
					if (status.full) begin
						last_d = 1'b1;
						state_d = bbfc_pkg::ST_EV_RD;
					end else begin
						state_d = bbfc_pkg::ST_WRITE;
					end
				end else begin
					state_d = bbfc_pkg::ST_EV_RD;
				end
			end
			bbfc_pkg::ST_EV_RD: begin
				cmd.evict_rd = 1'b1;
				state_d = bbfc_pkg::ST_EVICT;
			end
			bbfc_pkg::ST_EVICT: begin
				cmd.evict = 1'b1;
				state_d = last_q ? bbfc_pkg::ST_WRITE : bbfc_pkg::ST_CHECK;
			end
			bbfc_pkg::ST_WRITE: begin
				cmd.write = 1'b1;
				state_d = bbfc_pkg::ST_DONE;
			end
			bbfc_pkg::ST_DONE: begin
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_d = bbfc_pkg::ST_IDLE;
				end
			end
			default: state_d = bbfc_pkg::ST_IDLE;
		endcase
	end
endmodule

// File: hw/rtl/bbfc_datapath.sv
// Datapath of the byte budget FIFO cache: entry memories, ring pointers,
// counters, budget register and output register. Depends on bbfc_pkg.
`include "byte_budget_fifo_cache_top_defines.svh"
module bbfc_datapath (
	input logic clk,
	input logic arst_n,
	input bbfc_pkg::in_item_t in_data,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	input bbfc_pkg::cmd_t cmd,
	output bbfc_pkg::status_t status,
	output logic out_valid,
	input logic out_stall,
	output bbfc_pkg::out_item_t out_data
);
	localparam logic [bbfc_pkg::CNT_W-1:0] DEPTH = bbfc_pkg::CNT_W'(bbfc_pkg::ENTRIES);
	localparam logic [bbfc_pkg::IDX_W-1:0] LAST = bbfc_pkg::IDX_W'(bbfc_pkg::ENTRIES - 1);

	bbfc_pkg::key_t key_mem [bbfc_pkg::ENTRIES];
	logic [31:0] size_mem [bbfc_pkg::ENTRIES];

	bbfc_pkg::in_item_t in_q;
	bbfc_pkg::key_t in_key, key_rd_s1;
	logic [31:0] size_rd_s1;
	logic [bbfc_pkg::IDX_W-1:0] rd_addr, addr_s1;
	logic rd_vld_s1;
	logic [bbfc_pkg::ENTRIES-1:0] valid_q;
	logic [bbfc_pkg::IDX_W-1:0] oldest_q, newest_q, slot_q;
	logic [bbfc_pkg::CNT_W-1:0] total_q, scan_q, group_q, evicted_q;
	logic [31:0] held_q, hit_q, miss_q, budget_q, room;
	logic found_q, stored_q, large_q, out_full_q;
	logic scan_issue, hit_key, hit_group;
	bbfc_pkg::out_item_t out_q;

	assign in_key = '{maker: in_q.maker_number, software: in_q.program_number,
		release_id: in_q.release_number, piece: in_q.piece_number};
	assign scan_issue = cmd.scan && (scan_q < DEPTH);
	assign rd_addr = cmd.evict_rd ? oldest_q : scan_q[bbfc_pkg::IDX_W-1:0];
	assign hit_group = rd_vld_s1 && valid_q[addr_s1] && key_rd_s1.maker == in_key.maker
		&& key_rd_s1.software == in_key.software && key_rd_s1.release_id == in_key.release_id;
	assign hit_key = hit_group && key_rd_s1.piece == in_key.piece;
	assign room = (budget_q > held_q) ? budget_q - held_q : 32'd0;

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			key_mem[newest_q] <= in_key;
			size_mem[newest_q] <= in_q.shard_bytes;
		end
		key_rd_s1 <= key_mem[rd_addr];
		size_rd_s1 <= size_mem[rd_addr];
		addr_s1 <= rd_addr;
		if (cmd.capture) in_q <= in_data;
		if (cmd.load) out_q <= '{found: found_q, stored: stored_q, too_large: large_q,
			slot_index: 6'(slot_q), evicted_count: 7'(evicted_q),
			group_count: 7'(group_q), used_bytes: held_q, hit_total: hit_q,
			miss_total: miss_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			oldest_q <= '0;
			newest_q <= '0;
			total_q <= '0;
			held_q <= '0;
			hit_q <= '0;
			miss_q <= '0;
			budget_q <= bbfc_pkg::BUDGET_RESET;
			scan_q <= '0;
			rd_vld_s1 <= 1'b0;
			found_q <= 1'b0;
			stored_q <= 1'b0;
			large_q <= 1'b0;
			slot_q <= '0;
			group_q <= '0;
			evicted_q <= '0;
			out_full_q <= 1'b0;
		end else begin
			if (cfg_we) budget_q <= cfg_wdata;
			rd_vld_s1 <= scan_issue;
			if (scan_issue) scan_q <= scan_q + 1'b1;
			if (cmd.capture) begin
				scan_q <= '0;
				found_q <= 1'b0;
				stored_q <= 1'b0;
				large_q <= 1'b0;
				slot_q <= '0;
				group_q <= '0;
				evicted_q <= '0;
			end
			if (cmd.scan) begin
				if (hit_key && !found_q && (in_q.operation == bbfc_pkg::OP_INSERT
					|| in_q.operation == bbfc_pkg::OP_LOOKUP)) begin
					found_q <= 1'b1;
					slot_q <= addr_s1;
				end
				if (hit_group && in_q.operation == bbfc_pkg::OP_COUNT)
					group_q <= group_q + 1'b1;
			end
			if (cmd.hit && hit_q != 32'hFFFF_FFFF) hit_q <= hit_q + 32'd1;
			if (cmd.miss && miss_q != 32'hFFFF_FFFF) miss_q <= miss_q + 32'd1;
			if (cmd.mark_large) large_q <= 1'b1;
			if (cmd.evict) begin
				held_q <= (held_q >= size_rd_s1) ? held_q - size_rd_s1 : 32'd0;
				valid_q[oldest_q] <= 1'b0;
				oldest_q <= (oldest_q == LAST) ? '0 : oldest_q + 1'b1;
				total_q <= total_q - 1'b1;
				evicted_q <= evicted_q + 1'b1;
			end
			if (cmd.write) begin
				valid_q[newest_q] <= 1'b1;
				newest_q <= (newest_q == LAST) ? '0 : newest_q + 1'b1;
				total_q <= total_q + 1'b1;
				held_q <= held_q + in_q.shard_bytes;
				stored_q <= 1'b1;
				slot_q <= newest_q;
			end
			if (cmd.load) out_full_q <= 1'b1;
			else if (!out_stall) out_full_q <= 1'b0;
		end
	end

	assign status = '{op: in_q.operation, found: found_q,
		too_large: (in_q.shard_bytes > budget_q), fits: (in_q.shard_bytes <= room),
		empty: (total_q == '0), full: (total_q >= DEPTH), scan_done: (scan_q == DEPTH),
		out_free: (!out_full_q || !out_stall)};
	assign out_valid = out_full_q;
	assign out_data = out_q;

	`BBFC_ASSERT_ALWAYS(a_total_matches_marks, $countones(valid_q) == 32'(total_q), "entry total differs from valid marks")
	`BBFC_ASSERT_ALWAYS(a_no_evict_empty, !cmd.evict || total_q != '0, "eviction from an empty table")
	`BBFC_ASSERT_ALWAYS(a_no_write_full, !cmd.write || total_q < DEPTH, "append to a full table")
	`BBFC_ASSERT_NEXT(a_write_marks, cmd.write, valid_q[$past(newest_q)], "appended slot not marked valid")
endmodule

// File: bench/testbench.sv
// Self-checking testbench for byte_budget_fifo_cache_top: random and directed cache
// transactions under several byte budgets, checked against an in-bench cache predictor.
// Depends on bbfc_pkg and the RTL of the block only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	bbfc_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	bbfc_pkg::out_item_t out_data;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	byte_budget_fifo_cache_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Predictor state of the shard table.
	logic [63:0] mk_tab [bbfc_pkg::ENTRIES];
	logic [63:0] pg_tab [bbfc_pkg::ENTRIES];
	logic [63:0] rl_tab [bbfc_pkg::ENTRIES];
	logic [63:0] pc_tab [bbfc_pkg::ENTRIES];
	logic [31:0] sz_tab [bbfc_pkg::ENTRIES];
	logic live_tab [bbfc_pkg::ENTRIES];
	int unsigned head_slot;
	int unsigned tail_slot;
	int unsigned live_entries;
	logic [31:0] held_bytes;
	logic [31:0] hits;
	logic [31:0] misses;
	logic [31:0] budget;

	bbfc_pkg::in_item_t pending_items [$];
	bbfc_pkg::out_item_t expected_results [$];
	logic [63:0] maker_pool [4];
	logic [63:0] program_pool [2];
	logic [63:0] release_pool [2];
	logic [63:0] piece_pool [16];

	int unsigned errors;
	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned idle_cycles;
	logic steady;

	function automatic int unsigned ring_next(int unsigned s);
		return (s + 1 >= bbfc_pkg::ENTRIES) ? 0 : s + 1;
	endfunction

	function automatic void drop_oldest();
		int unsigned s;
		s = head_slot;
		held_bytes = (held_bytes >= sz_tab[s]) ? held_bytes - sz_tab[s] : 32'd0;
		live_tab[s] = 1'b0;
		head_slot = ring_next(s);
		live_entries--;
	endfunction

	function automatic bbfc_pkg::out_item_t cache_step(bbfc_pkg::in_item_t it);
		bbfc_pkg::out_item_t r;
		int found_at;
		logic [31:0] room;
		r = '0;
		found_at = -1;
		for (int i = 0; i < bbfc_pkg::ENTRIES; i++) begin
			if (found_at < 0 && live_tab[i] && mk_tab[i] == it.maker_number
					&& pg_tab[i] == it.program_number && rl_tab[i] == it.release_number
					&& pc_tab[i] == it.piece_number)
				found_at = i;
		end
		case (bbfc_pkg::op_t'(it.operation))
			bbfc_pkg::OP_INSERT: begin
				if (found_at >= 0) begin
					r.found = 1'b1;
					r.slot_index = found_at[5:0];
					if (hits != 32'hFFFF_FFFF)
						hits++;
				end else begin
					if (misses != 32'hFFFF_FFFF)
						misses++;
					if (it.shard_bytes > budget) begin
						r.too_large = 1'b1;
					end else begin
						forever begin
							room = (budget > held_bytes) ? budget - held_bytes : 32'd0;
							if (it.shard_bytes <= room || live_entries == 0)
								break;
							drop_oldest();
							r.evicted_count++;
						end
						if (live_entries >= bbfc_pkg::ENTRIES) begin
							drop_oldest();
							r.evicted_count++;
						end
						mk_tab[tail_slot] = it.maker_number;
						pg_tab[tail_slot] = it.program_number;
						rl_tab[tail_slot] = it.release_number;
						pc_tab[tail_slot] = it.piece_number;
						sz_tab[tail_slot] = it.shard_bytes;
						live_tab[tail_slot] = 1'b1;
						r.slot_index = tail_slot[5:0];
						tail_slot = ring_next(tail_slot);
						live_entries++;
						held_bytes += it.shard_bytes;
						r.stored = 1'b1;
					end
				end
			end
			bbfc_pkg::OP_LOOKUP: begin
				if (found_at >= 0) begin
					r.found = 1'b1;
					r.slot_index = found_at[5:0];
				end
			end
			bbfc_pkg::OP_COUNT: begin
				for (int i = 0; i < bbfc_pkg::ENTRIES; i++)
					if (live_tab[i] && mk_tab[i] == it.maker_number
							&& pg_tab[i] == it.program_number
							&& rl_tab[i] == it.release_number)
						r.group_count++;
			end
			default: ;
		endcase
		r.used_bytes = held_bytes;
		r.hit_total = hits;
		r.miss_total = misses;
		return r;
	endfunction

	function automatic logic [63:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] pick_size();
		int unsigned pick;
		logic [31:0] cap;
		pick = $urandom_range(0, 99);
		cap = (budget > 32'h0010_0000) ? 32'd4096 : budget / 5;
		if (pick < 5)
			return $urandom;
		if (pick < 8)
			return budget;
		if (pick < 10 && budget != 32'hFFFF_FFFF)
			return budget + 1;
		return $urandom_range(0, cap);
	endfunction

	function automatic bbfc_pkg::in_item_t make_item();
		bbfc_pkg::in_item_t it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			it.operation = bbfc_pkg::OP_INSERT;
		else if (pick < 75)
			it.operation = bbfc_pkg::OP_LOOKUP;
		else if (pick < 92)
			it.operation = bbfc_pkg::OP_COUNT;
		else
			it.operation = bbfc_pkg::OP_NONE;
		if ($urandom_range(0, 99) < 5) begin
			it.maker_number = wide_random();
			it.program_number = wide_random();
			it.release_number = wide_random();
			it.piece_number = wide_random();
		end else begin
			it.maker_number = maker_pool[$urandom_range(0, 3)];
			it.program_number = program_pool[$urandom_range(0, 1)];
			it.release_number = release_pool[$urandom_range(0, 1)];
			it.piece_number = piece_pool[$urandom_range(0, 15)];
		end
		it.shard_bytes = pick_size();
		return it;
	endfunction

	function automatic bbfc_pkg::in_item_t fixed_item(bbfc_pkg::op_t op, logic [63:0] key,
			logic [31:0] size);
		bbfc_pkg::in_item_t it;
		it.operation = op;
		it.maker_number = key;
		it.program_number = key;
		it.release_number = key;
		it.piece_number = key;
		it.shard_bytes = size;
		return it;
	endfunction

	function automatic void enqueue_item(bbfc_pkg::in_item_t it);
		pending_items = {pending_items, it};
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch in result %0d, %s: got %0h, expected %0h", results_seen, what,
			got, want);
		errors++;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_budget(logic [31:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		budget = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic queue_random(int unsigned n);
		repeat (n) enqueue_item(make_item());
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results = {expected_results, cache_step(in_data)};
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
					in_data <= pending_items[0];
					pending_items.delete(0);
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("result %0d arrived with no transaction outstanding", results_seen);
					errors++;
				end else begin
					bbfc_pkg::out_item_t want;
					want = expected_results[0];
					expected_results.delete(0);
					if (out_data.found !== want.found)
						report_mismatch("found", out_data.found, want.found);
					if (out_data.stored !== want.stored)
						report_mismatch("stored", out_data.stored, want.stored);
					if (out_data.too_large !== want.too_large)
						report_mismatch("too_large", out_data.too_large, want.too_large);
					if (out_data.slot_index !== want.slot_index)
						report_mismatch("slot_index", out_data.slot_index, want.slot_index);
					if (out_data.evicted_count !== want.evicted_count)
						report_mismatch("evicted_count", out_data.evicted_count,
							want.evicted_count);
					if (out_data.group_count !== want.group_count)
						report_mismatch("group_count", out_data.group_count, want.group_count);
					if (out_data.used_bytes !== want.used_bytes)
						report_mismatch("used_bytes", out_data.used_bytes, want.used_bytes);
					if (out_data.hit_total !== want.hit_total)
						report_mismatch("hit_total", out_data.hit_total, want.hit_total);
					if (out_data.miss_total !== want.miss_total)
						report_mismatch("miss_total", out_data.miss_total, want.miss_total);
				end
				results_seen++;
			end
			out_stall <= !steady && $urandom_range(0, 99) < 14;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		steady = 1'b0;
		for (int i = 0; i < bbfc_pkg::ENTRIES; i++) begin
			mk_tab[i] = '0;
			pg_tab[i] = '0;
			rl_tab[i] = '0;
			pc_tab[i] = '0;
			sz_tab[i] = '0;
			live_tab[i] = 1'b0;
		end
		head_slot = 0;
		tail_slot = 0;
		live_entries = 0;
		held_bytes = '0;
		hits = '0;
		misses = '0;
		budget = bbfc_pkg::BUDGET_RESET;
		maker_pool[0] = '0;
		maker_pool[1] = '1;
		maker_pool[2] = wide_random();
		maker_pool[3] = wide_random();
		for (int i = 0; i < 2; i++) begin
			program_pool[i] = wide_random();
			release_pool[i] = wide_random();
		end
		piece_pool[0] = '0;
		piece_pool[1] = '1;
		for (int i = 2; i < 16; i++)
			piece_pool[i] = wide_random();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: extreme keys and sizes, every operation, oversized shards.
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, '0, '0));
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, '1, 32'hFFFF_FFFF));
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, '1, bbfc_pkg::BUDGET_RESET));
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, '1, 32'd7));
		enqueue_item(fixed_item(bbfc_pkg::OP_LOOKUP, '1, '0));
		enqueue_item(fixed_item(bbfc_pkg::OP_LOOKUP, 64'h5, '0));
		enqueue_item(fixed_item(bbfc_pkg::OP_COUNT, '0, '1));
		enqueue_item(fixed_item(bbfc_pkg::OP_COUNT, '1, '0));
		enqueue_item(fixed_item(bbfc_pkg::OP_NONE, '1, '1));
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, 64'h9, bbfc_pkg::BUDGET_RESET + 1));
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, 64'hA, 32'd600000));
		write_budget(32'd300);
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, 64'hB, 32'd300));
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, 64'hC, 32'd301));
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, 64'hD, 32'd100));
		write_budget(32'd0);
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, 64'hE, 32'd0));
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, 64'hF, 32'd1));
		enqueue_item(fixed_item(bbfc_pkg::OP_INSERT, 64'hE, 32'd1));

		write_budget(32'hFFFF_FFFF);
		queue_random(350);
		write_budget(32'd3000);
		queue_random(250);
		write_budget(bbfc_pkg::BUDGET_RESET);
		queue_random(350);
		write_budget(32'd20000);
		queue_random(350);
		write_budget(32'd0);
		queue_random(100);
		write_budget(32'hFFFF_FFFF);
		queue_random(200);
		wait_idle();
		steady = 1'b1;
		write_budget(32'd50000);
		queue_random(300);
		wait_idle();
		steady = 1'b0;
		repeat (300) @(posedge clk);

		$display("covered %0d cache transactions and %0d results over several budget settings",
			items_sent, results_seen);
		$display("%0d mismatches found", errors);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
